// ----- design/assert_macros.svh -----
// Assertion macros shared by the sequencer's modules.
// Each macro samples on clk and is switched off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Expression must never be true at a clock edge out of reset
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

// ----- design/lcdnx_pkg.sv -----
// Types and constants for the character LCD nibble sequencer.
// No dependencies; used by the controller, the datapath and the top level.
package lcdnx_pkg;

	// Command codes of the input transaction
	typedef enum logic [2:0] {
		CMD_INIT    = 3'd0,
		CMD_BYTE    = 3'd1,
		CMD_DATA    = 3'd2,
		CMD_CURSOR  = 3'd3,
		CMD_CLEAR   = 3'd4,
		CMD_BL_ON   = 3'd5,
		CMD_BL_OFF  = 3'd6
	} cmd_e;

	// Write phases of one nibble: plain, enable high, enable low
	localparam logic [1:0] PH_PLAIN = 2'd0;
	localparam logic [1:0] PH_EN_HI = 2'd1;
	localparam logic [1:0] PH_EN_LO = 2'd2;

	// Nibble counts, less one
	localparam logic [3:0] INIT_NIB_LAST = 4'd11;
	localparam logic [3:0] BYTE_NIB_LAST = 4'd1;

	// Fixed display bytes
	localparam logic [7:0] LCD_CLEAR      = 8'h01;
	localparam logic [7:0] LCD_SET_DDRAM  = 8'h80;
	localparam logic [7:0] LCD_ROW1_OFS   = 8'h40;

	// Waits in microseconds
	localparam logic [12:0] WAIT_EN_HI   = 13'd1;
	localparam logic [12:0] WAIT_EN_LO   = 13'd50;
	localparam logic [12:0] WAIT_POWERUP = 13'd5050;
	localparam logic [12:0] WAIT_INIT    = 13'd200;
	localparam logic [12:0] WAIT_CLEAR   = 13'd2050;

	// Nibble positions that carry a longer wait, in the init sequence and in a byte
	localparam logic [3:0] INIT_NIB_FIRST = 4'd0;
	localparam logic [3:0] INIT_NIB_SECOND = 4'd1;
	localparam logic [3:0] INIT_NIB_THIRD = 4'd2;
	localparam logic [3:0] INIT_NIB_CLEAR = 4'd9;
	localparam logic [3:0] BYTE_NIB_LOW   = 4'd1;

	// Controller to datapath commands
	typedef struct packed {
		logic       capture;
		logic       emit;
		logic [3:0] nib;
		logic [1:0] phase;
		logic       last;
	} ctl_t;

	// Datapath to controller status
	typedef struct packed {
		logic out_free;
	} dp_stat_t;

	// Init sequence: three 0x3 nibbles, 0x2, then 0x28, 0x0C, 0x01, 0x06
	function automatic logic [3:0] init_nibble(input logic [3:0] idx);
		logic [3:0] n;
		case (idx)
			4'd0, 4'd1, 4'd2: n = 4'h3;
			4'd3, 4'd4:       n = 4'h2;
			4'd5:             n = 4'h8;
			4'd6:             n = 4'h0;
			4'd7:             n = 4'hC;
			4'd8:             n = 4'h0;
			4'd9:             n = 4'h1;
			4'd10:            n = 4'h0;
			4'd11:            n = 4'h6;
			default:          n = 4'h0;
		endcase
		return n;
	endfunction

endpackage

// ----- design/lcdnx_if.sv -----
// Channel interfaces of the LCD nibble sequencer: command in, expander
// write out, and the address register write. Uses nothing else.
interface lcdnx_cmd_if;
	logic       valid;
	logic       ready;
	logic [2:0] cmd;
	logic [7:0] value;
	logic [5:0] column;
	logic       row;

	modport source (output valid, cmd, value, column, row, input ready);
	modport sink (input valid, cmd, value, column, row, output ready);
endinterface

interface lcdnx_wr_if;
	logic        valid;
	logic        ready;
	logic [7:0]  address_byte;
	logic [7:0]  expander_byte;
	logic [12:0] wait_us;
	logic        last;

	modport source (output valid, address_byte, expander_byte, wait_us, last, input ready);
	modport sink (input valid, address_byte, expander_byte, wait_us, last, output ready);
endinterface

interface lcdnx_cfg_if;
	logic       valid;
	logic       ready;
	logic [6:0] i2c_address;

	modport source (output valid, i2c_address, input ready);
	modport sink (input valid, i2c_address, output ready);
endinterface

// ----- design/lcdnx_ctrl.sv -----
// Sequencer controller: walks nibbles and write phases of one command.
// Depends on lcdnx_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lcdnx_ctrl import lcdnx_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  cmd_e     in_cmd,
	input  dp_stat_t stat,
	output ctl_t     ctl
);

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t     state_q;
	logic [3:0] nib_q;
	logic [3:0] nib_last_q;
	logic [1:0] phase_q;
	logic       single_q;
	logic       last_w;

	// Final write: the single backlight write, or last phase of last nibble
	assign last_w = single_q || (nib_q == nib_last_q && phase_q == PH_EN_LO);

	assign in_ready = (state_q == ST_IDLE);

	// Drive datapath commands
	always_comb begin
		ctl.capture = in_valid && (state_q == ST_IDLE);
		ctl.emit    = (state_q == ST_RUN) && stat.out_free;
		ctl.nib     = nib_q;
		ctl.phase   = phase_q;
		ctl.last    = last_w;
	end

	// Hold state; advance phase and nibble on each write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			nib_q      <= '0;
			nib_last_q <= '0;
			phase_q    <= PH_PLAIN;
			single_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					nib_q   <= '0;
					phase_q <= PH_PLAIN;
					if (in_valid) begin
						unique case (in_cmd) inside
							CMD_INIT: begin
								nib_last_q <= INIT_NIB_LAST;
								single_q   <= 1'b0;
								state_q    <= ST_RUN;
							end
							CMD_BYTE, CMD_DATA, CMD_CURSOR, CMD_CLEAR: begin
								nib_last_q <= BYTE_NIB_LAST;
								single_q   <= 1'b0;
								state_q    <= ST_RUN;
							end
							CMD_BL_ON, CMD_BL_OFF: begin
								nib_last_q <= '0;
								single_q   <= 1'b1;
								state_q    <= ST_RUN;
							end
							default: begin
								// unused code: drop it
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_RUN: begin
					if (stat.out_free) begin
						if (last_w) begin
							state_q <= ST_IDLE;
						end else if (phase_q == PH_EN_LO) begin
							phase_q <= PH_PLAIN;
							nib_q   <= nib_q + 4'd1;
						end else begin
							phase_q <= phase_q + 2'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`ASSERT_NEVER(a_phase_range, phase_q == 2'd3, "write phase out of range")
	`ASSERT_CLK(a_nib_range, state_q == ST_RUN |-> nib_q <= nib_last_q,
		"nibble index beyond command length")
	`ASSERT_CLK(a_last_ends, ctl.emit && ctl.last |=> state_q == ST_IDLE,
		"controller kept running after final write")

endmodule

// ----- design/lcdnx_dp.sv -----
// Sequencer datapath: command capture, address and backlight registers,
// expander byte and wait build, output register. Depends on lcdnx_pkg.
`include "assert_macros.svh"

module lcdnx_dp import lcdnx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  ctl_t        ctl,
	output dp_stat_t    stat,
	input  cmd_e        in_cmd,
	input  logic [7:0]  in_value,
	input  logic [5:0]  in_column,
	input  logic        in_row,
	input  logic        cfg_valid,
	input  logic [6:0]  cfg_addr,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_address_byte,
	output logic [7:0]  out_expander_byte,
	output logic [12:0] out_wait_us,
	output logic        out_last
);

	cmd_e        cmd_q;
	logic [7:0]  byte_q;
	logic        sel_q;
	logic        bl_q;
	logic [6:0]  addr_q;
	logic        out_valid_q;
	logic [7:0]  exp_q;
	logic [12:0] wait_q;
	logic        last_q;
	logic [7:0]  cap_byte;
	logic [3:0]  nib;
	logic [7:0]  exp_w;
	logic [12:0] wait_w;

	assign stat.out_free = !out_valid_q || out_ready;

	// Pick the display byte of a command
	always_comb begin
		case (in_cmd)
			CMD_CURSOR: cap_byte = LCD_SET_DDRAM |
				(8'({2'b00, in_column}) + (in_row ? LCD_ROW1_OFS : 8'h00));
			CMD_CLEAR:  cap_byte = LCD_CLEAR;
			default:    cap_byte = in_value;
		endcase
	end

	// Build expander byte for the current phase
	always_comb begin
		if (cmd_q == CMD_INIT) begin
			nib = init_nibble(ctl.nib);
		end else if (ctl.nib == BYTE_NIB_LOW) begin
			nib = byte_q[3:0];
		end else begin
			nib = byte_q[7:4];
		end
		if (cmd_q == CMD_BL_ON || cmd_q == CMD_BL_OFF) begin
			exp_w = {4'h0, bl_q, 3'b000};
		end else begin
			exp_w = {nib, bl_q, ctl.phase == PH_EN_HI, 1'b0, sel_q};
		end
	end

	// Wait after the write: longer ones close init steps and clear
	always_comb begin
		case (ctl.phase)
			PH_EN_HI: wait_w = WAIT_EN_HI;
			PH_EN_LO: begin
				wait_w = WAIT_EN_LO;
				if (cmd_q == CMD_INIT) begin
					if (ctl.nib == INIT_NIB_FIRST) begin
						wait_w = WAIT_POWERUP;
					end else if (ctl.nib == INIT_NIB_SECOND
							|| ctl.nib == INIT_NIB_THIRD) begin
						wait_w = WAIT_INIT;
					end else if (ctl.nib == INIT_NIB_CLEAR) begin
						wait_w = WAIT_CLEAR;
					end
				end else if (cmd_q == CMD_CLEAR && ctl.nib == BYTE_NIB_LOW) begin
					wait_w = WAIT_CLEAR;
				end
			end
			default: wait_w = '0;
		endcase
	end

	// Hold control registers: address, backlight, command, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q      <= 7'd39;
			bl_q        <= 1'b1;
			out_valid_q <= 1'b0;
			cmd_q       <= CMD_INIT;
		end else begin
			if (cfg_valid) begin
				addr_q <= cfg_addr;
			end
			if (ctl.capture) begin
				cmd_q <= in_cmd;
				if (in_cmd == CMD_BL_ON) begin
					bl_q <= 1'b1;
				end else if (in_cmd == CMD_BL_OFF) begin
					bl_q <= 1'b0;
				end
			end
			if (ctl.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			byte_q <= cap_byte;
			sel_q  <= (in_cmd == CMD_DATA);
		end
		if (ctl.emit) begin
			exp_q  <= exp_w;
			wait_q <= wait_w;
			last_q <= ctl.last;
		end
	end

	assign out_valid         = out_valid_q;
	assign out_address_byte  = {addr_q, 1'b0};
	assign out_expander_byte = exp_q;
	assign out_wait_us       = wait_q;
	assign out_last          = last_q;

	`ASSERT_CLK(a_rise_on_emit, $rose(out_valid_q) |-> $past(ctl.emit),
		"output became valid without a write step")
	`ASSERT_CLK(a_wait_range, out_valid_q |-> wait_q <= WAIT_POWERUP,
		"wait beyond longest step")
	`ASSERT_CLK(a_drain, out_valid_q && out_ready && !ctl.emit |=> !out_valid_q,
		"taken write still shown")

endmodule

// ----- design/char_lcd_nibble_expander_sequencer_top.sv -----
// Channel   | Dir | Payload
// cmd_ch    | in  | cmd, value, column, row
// wr_ch     | out | address_byte, expander_byte, wait_us, last
// cfg_ch    | in  | i2c_address (always ready)
//
// A command is taken while idle, then one expander write per cycle while the
// output register drains: 6 writes for a byte command, 36 for init, 1 for a
// backlight command; the nibble and phase counters of the controller set this.
// A stalled wr_ch holds the controller in place. arst_n clears the address
// to 0x27, backlight on, and leaves the block idle and ready.
// Top level of the LCD nibble sequencer; depends on lcdnx_pkg, lcdnx_if,
// lcdnx_ctrl and lcdnx_dp.
module char_lcd_nibble_expander_sequencer_top import lcdnx_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	lcdnx_cmd_if.sink  cmd_ch,
	lcdnx_wr_if.source wr_ch,
	lcdnx_cfg_if.sink  cfg_ch
);

	ctl_t     ctl;
	dp_stat_t stat;

	assign cfg_ch.ready = 1'b1;

	lcdnx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd_ch.valid),
		.in_ready (cmd_ch.ready),
		.in_cmd   (cmd_e'(cmd_ch.cmd)),
		.stat     (stat),
		.ctl      (ctl)
	);

	lcdnx_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.ctl               (ctl),
		.stat              (stat),
		.in_cmd            (cmd_e'(cmd_ch.cmd)),
		.in_value          (cmd_ch.value),
		.in_column         (cmd_ch.column),
		.in_row            (cmd_ch.row),
		.cfg_valid         (cfg_ch.valid),
		.cfg_addr          (cfg_ch.i2c_address),
		.out_valid         (wr_ch.valid),
		.out_ready         (wr_ch.ready),
		.out_address_byte  (wr_ch.address_byte),
		.out_expander_byte (wr_ch.expander_byte),
		.out_wait_us       (wr_ch.wait_us),
		.out_last          (wr_ch.last)
	);

endmodule

// ----- bench/lcd_write_scoreboard.sv -----
`timescale 1ns / 1ps
// Scoreboard for the LCD nibble sequencer: predicts the expander writes of each command
// and compares them with the writes that leave the block. Uses lcdnx_pkg and lcdnx_if.
module lcd_write_scoreboard import lcdnx_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	lcdnx_cmd_if  cmd_ch,
	lcdnx_wr_if   wr_ch,
	lcdnx_cfg_if  cfg_ch,
	output int    mismatch_count,
	output int    writes_pending
);

	// Expander byte fields and fixed display bytes
	localparam logic [7:0]  ENABLE_MASK   = 8'h04;
	localparam logic [7:0]  LAMP_MASK     = 8'h08;
	localparam logic [7:0]  NIBBLE_MASK   = 8'hF0;
	localparam logic        SEL_CMD       = 1'b0;
	localparam logic        SEL_DATA      = 1'b1;
	localparam logic [7:0]  WAKE_NIBBLE   = 8'h30;
	localparam logic [7:0]  FOURBIT_NIBBLE = 8'h20;
	localparam logic [7:0]  FUNC_SET      = 8'h28;
	localparam logic [7:0]  DISPLAY_ON    = 8'h0C;
	localparam logic [7:0]  ENTRY_MODE    = 8'h06;
	localparam logic [7:0]  NO_NIBBLE     = 8'h00;
	localparam logic [6:0]  ADDR_AT_RESET = 7'h27;
	localparam logic [12:0] EXTRA_POWERUP = 13'd5000;
	localparam logic [12:0] EXTRA_WAKE    = 13'd150;
	localparam logic [12:0] EXTRA_CLEAR   = 13'd2000;
	localparam logic [12:0] NO_WAIT       = 13'd0;

	typedef struct packed {
		logic [7:0]  address_byte;
		logic [7:0]  expander_byte;
		logic [12:0] wait_us;
		logic        last;
	} expander_write_t;

	logic [6:0]      bus_addr;
	logic            lamp_on;
	expander_write_t expected_writes[$];
	int              writes_seen;

	task automatic report(input string what, input int got, input int want);
		$display("write %0d: %s is 0x%0h, predicted 0x%0h", writes_seen, what, got, want);
		mismatch_count++;
	endtask

	task automatic queue_write(input logic [7:0] lines, input logic [12:0] wait_us);
		expander_write_t w;
		w.address_byte = {bus_addr, 1'b0};
		w.expander_byte = lines | (lamp_on ? LAMP_MASK : 8'h00);
		w.wait_us = wait_us;
		w.last = 1'b0;
		expected_writes.push_back(w);
	endtask

	// Plain, enable high, enable low
	task automatic queue_nibble(input logic [7:0] lines);
		queue_write(lines, NO_WAIT);
		queue_write(lines | ENABLE_MASK, WAIT_EN_HI);
		queue_write(lines & ~ENABLE_MASK, WAIT_EN_LO);
	endtask

	task automatic queue_display_byte(input logic [7:0] d, input logic sel);
		queue_nibble((d & NIBBLE_MASK) | {7'd0, sel});
		queue_nibble({d[3:0], 4'h0} | {7'd0, sel});
	endtask

	// Lengthen the wait of the newest write
	task automatic stretch_wait(input logic [12:0] extra);
		int n;
		n = expected_writes.size();
		expected_writes[n - 1].wait_us = expected_writes[n - 1].wait_us + extra;
	endtask

	task automatic expand_command(input logic [2:0] code, input logic [7:0] value,
			input logic [5:0] column, input logic row);
		int start_count;
		logic [7:0] ddram;
		start_count = expected_writes.size();
		ddram = LCD_SET_DDRAM | ({2'b00, column} + (row ? LCD_ROW1_OFS : 8'h00));
		case (code)
			CMD_INIT: begin
				queue_nibble(WAKE_NIBBLE);
				stretch_wait(EXTRA_POWERUP);
				queue_nibble(WAKE_NIBBLE);
				stretch_wait(EXTRA_WAKE);
				queue_nibble(WAKE_NIBBLE);
				stretch_wait(EXTRA_WAKE);
				queue_nibble(FOURBIT_NIBBLE);
				queue_display_byte(FUNC_SET, SEL_CMD);
				queue_display_byte(DISPLAY_ON, SEL_CMD);
				queue_display_byte(LCD_CLEAR, SEL_CMD);
				stretch_wait(EXTRA_CLEAR);
				queue_display_byte(ENTRY_MODE, SEL_CMD);
			end
			CMD_BYTE:   queue_display_byte(value, SEL_CMD);
			CMD_DATA:   queue_display_byte(value, SEL_DATA);
			CMD_CURSOR: queue_display_byte(ddram, SEL_CMD);
			CMD_CLEAR: begin
				queue_display_byte(LCD_CLEAR, SEL_CMD);
				stretch_wait(EXTRA_CLEAR);
			end
			CMD_BL_ON: begin
				lamp_on = 1'b1;
				queue_write(NO_NIBBLE, NO_WAIT);
			end
			CMD_BL_OFF: begin
				lamp_on = 1'b0;
				queue_write(NO_NIBBLE, NO_WAIT);
			end
			default: ;
		endcase
		// Mark the final write of this command
		if (expected_writes.size() > start_count)
			expected_writes[expected_writes.size() - 1].last = 1'b1;
	endtask

	// Compare outgoing writes, then take register and command transactions
	always @(posedge clk or negedge arst_n) begin
		expander_write_t want;
		if (!arst_n) begin
			bus_addr = ADDR_AT_RESET;
			lamp_on = 1'b1;
			expected_writes.delete();
			writes_seen = 0;
			mismatch_count = 0;
			writes_pending = 0;
		end else begin
			if (wr_ch.valid && wr_ch.ready) begin
				if (expected_writes.size() == 0) begin
					report("unpredicted write, expander_byte", wr_ch.expander_byte, 0);
				end else begin
					want = expected_writes.pop_front();
					if (wr_ch.address_byte !== want.address_byte)
						report("address_byte", wr_ch.address_byte, want.address_byte);
					if (wr_ch.expander_byte !== want.expander_byte)
						report("expander_byte", wr_ch.expander_byte, want.expander_byte);
					if (wr_ch.wait_us !== want.wait_us)
						report("wait_us", wr_ch.wait_us, want.wait_us);
					if (wr_ch.last !== want.last)
						report("last", wr_ch.last, want.last);
				end
				writes_seen++;
			end
			if (cfg_ch.valid && cfg_ch.ready)
				bus_addr = cfg_ch.i2c_address;
			if (cmd_ch.valid && cmd_ch.ready)
				expand_command(cmd_ch.cmd, cmd_ch.value, cmd_ch.column, cmd_ch.row);
			writes_pending = expected_writes.size();
		end
	end

endmodule

// ----- bench/char_lcd_nibble_expander_sequencer_top_test.sv -----
`timescale 1ns / 1ps
// Testbench top for the LCD nibble sequencer: drives commands and address writes,
// stalls the write channel and gives the verdict. Uses lcdnx_pkg, lcdnx_if, lcd_write_scoreboard.
module char_lcd_nibble_expander_sequencer_top_test;
	import lcdnx_pkg::*;

	localparam int         ITEMS       = 500;
	localparam int         PHASES      = 5;
	localparam int         IDLE_PCT    = 18;
	localparam int         HOLDOFF     = 8;
	localparam int         TAIL        = 20;
	localparam int         CYCLE_LIMIT = 400000;
	localparam logic [2:0] CMD_UNUSED  = 3'd7;

	logic clk = 1'b0;
	logic arst_n;
	bit   steady;
	int   cycles = 0;
	int   mismatch_count;
	int   writes_pending;

	lcdnx_cmd_if cmd_ch();
	lcdnx_wr_if  wr_ch();
	lcdnx_cfg_if cfg_ch();

	char_lcd_nibble_expander_sequencer_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd_ch (cmd_ch),
		.wr_ch  (wr_ch),
		.cfg_ch (cfg_ch)
	);

	lcd_write_scoreboard scoreboard (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_ch         (cmd_ch),
		.wr_ch          (wr_ch),
		.cfg_ch         (cfg_ch),
		.mismatch_count (mismatch_count),
		.writes_pending (writes_pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Stall the write channel at random, except during a steady stretch
	always begin
		wr_ch.ready = steady || ($urandom_range(99) >= IDLE_PCT);
		@(negedge clk);
	end

	// Abandon a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("char_lcd_nibble_expander_sequencer_top_test: errors");
			$finish;
		end
	end

	// Offer one command transaction and hold it until taken
	task automatic send_command(input logic [2:0] code, input logic [7:0] value,
			input logic [5:0] column, input logic row);
		@(negedge clk);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			cmd_ch.valid = 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid = 1'b1;
		cmd_ch.cmd = code;
		cmd_ch.value = value;
		cmd_ch.column = column;
		cmd_ch.row = row;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
	endtask

	// Drop valid and let every predicted write leave the block
	task automatic drain();
		@(negedge clk);
		cmd_ch.valid = 1'b0;
		while (writes_pending != 0)
			@(negedge clk);
	endtask

	task automatic write_address(input logic [6:0] addr);
		drain();
		// An unused command may still be in flight
		repeat (HOLDOFF) @(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.i2c_address = addr;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// Mostly display traffic, some init and backlight, a few unused codes
	task automatic random_command();
		int roll;
		logic [2:0] code;
		roll = $urandom_range(99);
		if (roll < 5)       code = CMD_INIT;
		else if (roll < 30) code = CMD_BYTE;
		else if (roll < 60) code = CMD_DATA;
		else if (roll < 75) code = CMD_CURSOR;
		else if (roll < 83) code = CMD_CLEAR;
		else if (roll < 90) code = CMD_BL_ON;
		else if (roll < 97) code = CMD_BL_OFF;
		else                code = CMD_UNUSED;
		send_command(code, 8'($urandom), 6'($urandom), 1'($urandom));
	endtask

	initial begin
		logic [6:0] addr;
		cmd_ch.valid = 1'b0;
		cmd_ch.cmd = CMD_INIT;
		cmd_ch.value = 8'h00;
		cmd_ch.column = 6'd0;
		cmd_ch.row = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.i2c_address = 7'h00;
		steady = 1'b0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: every command, field extremes, backlight both ways, unused code
		send_command(CMD_INIT, 8'h00, 6'd0, 1'b0);
		send_command(CMD_BYTE, 8'h00, 6'd0, 1'b0);
		send_command(CMD_BYTE, 8'hFF, 6'd63, 1'b1);
		send_command(CMD_DATA, 8'h00, 6'd0, 1'b0);
		send_command(CMD_DATA, 8'hFF, 6'd63, 1'b1);
		send_command(CMD_DATA, 8'hA5, 6'd21, 1'b0);
		send_command(CMD_CURSOR, 8'hFF, 6'd0, 1'b0);
		send_command(CMD_CURSOR, 8'h00, 6'd63, 1'b0);
		send_command(CMD_CURSOR, 8'hFF, 6'd0, 1'b1);
		send_command(CMD_CURSOR, 8'h00, 6'd63, 1'b1);
		send_command(CMD_CLEAR, 8'hFF, 6'd63, 1'b1);
		send_command(CMD_BL_OFF, 8'hFF, 6'd63, 1'b1);
		send_command(CMD_DATA, 8'h5A, 6'd0, 1'b0);
		send_command(CMD_INIT, 8'hFF, 6'd63, 1'b1);
		send_command(CMD_BL_OFF, 8'h00, 6'd0, 1'b0);
		send_command(CMD_BL_ON, 8'h00, 6'd0, 1'b0);
		send_command(CMD_BL_ON, 8'hFF, 6'd63, 1'b1);
		send_command(CMD_UNUSED, 8'h00, 6'd0, 1'b0);
		send_command(CMD_UNUSED, 8'hFF, 6'd63, 1'b1);
		send_command(CMD_BYTE, 8'h3C, 6'd42, 1'b1);

		// Random phases, each under its own bus address
		for (int phase = 0; phase < PHASES; phase++) begin
			addr = (phase == 0) ? 7'h00 : (phase == 1) ? 7'h7F :
				(phase == PHASES - 1) ? 7'h27 : 7'($urandom);
			write_address(addr);
			steady = (phase == 2);
			repeat (ITEMS / PHASES) random_command();
			steady = 1'b0;
		end

		drain();
		repeat (TAIL) @(posedge clk);
		if (mismatch_count == 0 && writes_pending == 0)
			$display("char_lcd_nibble_expander_sequencer_top_test: clean");
		else
			$display("char_lcd_nibble_expander_sequencer_top_test: errors");
		$finish;
	end

endmodule
